// ===== rtl/idfd_pkg.sv =====
// Shared types, codes and the palette table of the laser frame decoder.
package idfd_pkg;

  // Classification made by the front end
  localparam logic [1:0] CLS_POINT    = 2'd0;
  localparam logic [1:0] CLS_HDR_PAL  = 2'd1;
  localparam logic [1:0] CLS_HDR_TRUE = 2'd2;
  localparam logic [1:0] CLS_HDR_BAD  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Open frame colour mode
  localparam logic [1:0] FK_NONE    = 2'd0;
  localparam logic [1:0] FK_PALETTE = 2'd1;
  localparam logic [1:0] FK_TRUE    = 2'd2;

  // Format bytes
  localparam logic [7:0] FMT_PAL_3D  = 8'd0;
  localparam logic [7:0] FMT_PAL_2D  = 8'd1;
  localparam logic [7:0] FMT_TRUE_3D = 8'd4;
  localparam logic [7:0] FMT_TRUE_2D = 8'd5;

  localparam int         ROM_ENTRIES = 64;
  localparam logic [7:0] BLANK_MASK  = 8'h40;
  localparam logic [17:0] REPEAT_MAX = 18'h3FFFF;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Config register indexes
  localparam logic REG_POINTS_PER_FRAME = 1'b0;

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] point_count;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  status;
    logic [7:0]  color_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] intensity;
    logic [17:0] repeat_count;
    logic        frame_last;
  } result_t;

  // Palette: {red, green, blue}
  localparam logic [23:0] PALETTE_ROM [ROM_ENTRIES] = '{
    24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000,
    24'hFF4000, 24'hFF5000, 24'hFF6000, 24'hFF7000,
    24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000,
    24'hFFC000, 24'hFFD000, 24'hFFE000, 24'hFFF000,
    24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00,
    24'h80FF00, 24'h60FF00, 24'h40FF00, 24'h20FF00,
    24'h00FF00, 24'h00FF20, 24'h00FF40, 24'h00FF60,
    24'h00FF80, 24'h00FFA0, 24'h00FFC0, 24'h00FFE0,
    24'h0082FF, 24'h0072FF, 24'h0068FF, 24'h0A60FF,
    24'h0052FF, 24'h004AFF, 24'h0040FF, 24'h0020FF,
    24'h0000FF, 24'h2000FF, 24'h4000FF, 24'h6000FF,
    24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF,
    24'hFF00FF, 24'hFF20FF, 24'hFF40FF, 24'hFF60FF,
    24'hFF80FF, 24'hFFA0FF, 24'hFFC0FF, 24'hFFE0FF,
    24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0,
    24'hFF8080, 24'hFF6060, 24'hFF4040, 24'hFF2020
  };

endpackage

// ===== rtl/idfd_front.sv =====
// Front end: accepts input beats, classifies them and writes the queue.
module idfd_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [7:0]          format_code,
  input  logic [15:0]         point_count,
  input  logic [15:0]         x_in,
  input  logic [15:0]         y_in,
  input  logic [7:0]          status,
  input  logic [7:0]          color_index,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  input  logic                q_full,
  output logic                q_write,
  output idfd_pkg::entry_t    q_entry
);
  import idfd_pkg::*;

  logic [1:0] cls;

  always_comb begin
    if (command) begin
      cls = CLS_POINT;
    end else if (format_code == FMT_PAL_3D || format_code == FMT_PAL_2D) begin
      cls = CLS_HDR_PAL;
    end else if (format_code == FMT_TRUE_3D || format_code == FMT_TRUE_2D) begin
      cls = CLS_HDR_TRUE;
    end else begin
      cls = CLS_HDR_BAD;
    end
  end

  assign in_ready = !q_full;
  assign q_write  = in_valid && !q_full;

  always_comb begin
    q_entry.cls         = cls;
    q_entry.point_count = point_count;
    q_entry.x           = x_in;
    q_entry.y           = y_in;
    q_entry.status      = status;
    q_entry.color_index = color_index;
    q_entry.red         = red_in;
    q_entry.green       = green_in;
    q_entry.blue        = blue_in;
  end

endmodule

// ===== rtl/idfd_queue.sv =====
// Short FIFO between the front end and the back end.
module idfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  idfd_pkg::entry_t wr_entry,
  input  logic             pop,
  output idfd_pkg::entry_t rd_entry,
  output logic             rd_valid,
  output logic             full
);
  import idfd_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign rd_valid = fill != '0;
  assign full     = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_entry;
  end

endmodule

// ===== rtl/idfd_back.sv =====
// Back end: frame state, point decode, repeat count divider and result register.
module idfd_back #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  idfd_pkg::entry_t  q_entry,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [16:0]       points_per_frame,
  output idfd_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_ready
);
  import idfd_pkg::*;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_MUL = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  localparam int LAST_ENTRY =
    ((PALETTE_ENTRIES < ROM_ENTRIES) ? PALETTE_ENTRIES : ROM_ENTRIES) - 1;
  localparam logic [15:0] LAST_IDX = 16'(LAST_ENTRY);

  localparam logic signed [35:0] OFS_MAX = 36'sd2147483647;
  localparam logic signed [35:0] OFS_MIN = -36'sd2147483648;

  logic [1:0]         state;
  logic [15:0]        points_remaining;
  logic [1:0]         frame_kind;
  logic signed [31:0] rate_offset;

  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [4:0]  bit_cnt;
  logic [1:0]  hdr_kind;
  logic [17:0] rep;
  logic [33:0] prod;

  logic               out_free;
  logic               hdr_ok;
  logic [1:0]         new_kind;
  logic signed [34:0] num;
  logic               num_small;
  logic [16:0]        rem_sh;
  logic [16:0]        rem_sub;
  logic               ge;
  logic [17:0]        q_sat;
  logic signed [35:0] nf_wide;
  logic [31:0]        nf_sat;

  logic        blank;
  logic [15:0] pal_word;
  logic [5:0]  rom_idx;
  logic [23:0] rom_rgb;
  logic [7:0]  r8, g8, b8, m8;
  logic        point_ok;
  result_t     run_res;
  result_t     hdr_res;

  assign out_free = !res_valid || res_ready;
  assign q_pop    = (state == ST_RUN) && q_valid && out_free;

  assign hdr_ok   = q_entry.cls == CLS_HDR_PAL || q_entry.cls == CLS_HDR_TRUE;
  assign new_kind = (q_entry.cls == CLS_HDR_PAL) ? FK_PALETTE : FK_TRUE;

  // numerator of the rounded repeat count: P - F + n/2
  assign num = $signed({18'b0, points_per_frame})
             - $signed({{3{rate_offset[31]}}, rate_offset})
             + $signed({20'b0, q_entry.point_count[15:1]});
  assign num_small = num < $signed({19'b0, q_entry.point_count});

  // restoring divider, one quotient bit per cycle; quotient shifts into dvd
  assign rem_sh  = {rem, dvd[31]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign q_sat   = (dvd[31:18] != '0) ? REPEAT_MAX : dvd[17:0];

  assign nf_wide = $signed({{4{rate_offset[31]}}, rate_offset})
                 + $signed({2'b0, prod})
                 - $signed({19'b0, points_per_frame});

  always_comb begin
    if (nf_wide > OFS_MAX) begin
      nf_sat = OFS_MAX[31:0];
    end else if (nf_wide < OFS_MIN) begin
      nf_sat = OFS_MIN[31:0];
    end else begin
      nf_sat = nf_wide[31:0];
    end
  end

  // point colour
  assign blank    = (q_entry.status & BLANK_MASK) != '0;
  assign pal_word = {q_entry.status, q_entry.color_index};
  assign rom_idx  = (pal_word > LAST_IDX) ? LAST_IDX[5:0] : pal_word[5:0];
  assign rom_rgb  = PALETTE_ROM[rom_idx];
  assign point_ok = frame_kind != FK_NONE && points_remaining != '0;

  always_comb begin
    if (blank) begin
      r8 = '0;
      g8 = '0;
      b8 = '0;
    end else if (frame_kind == FK_PALETTE) begin
      r8 = rom_rgb[23:16];
      g8 = rom_rgb[15:8];
      b8 = rom_rgb[7:0];
    end else begin
      r8 = q_entry.red;
      g8 = q_entry.green;
      b8 = q_entry.blue;
    end
    m8 = r8;
    if (g8 > m8) m8 = g8;
    if (b8 > m8) m8 = b8;
  end

  always_comb begin
    run_res = '0;
    unique case (q_entry.cls)
      CLS_POINT: begin
        if (point_ok) begin
          run_res.kind       = KIND_POINT;
          run_res.x          = q_entry.x;
          run_res.y          = q_entry.y;
          run_res.red        = {r8, 8'h00};
          run_res.green      = {g8, 8'h00};
          run_res.blue       = {b8, 8'h00};
          run_res.intensity  = {m8, 8'h00};
          run_res.frame_last = points_remaining == 16'd1;
        end else begin
          run_res.kind = KIND_ERROR;
        end
      end
      CLS_HDR_BAD: run_res.kind = KIND_ERROR;
      CLS_HDR_PAL, CLS_HDR_TRUE: begin
        if (q_entry.point_count == '0) begin
          run_res.kind = KIND_END;
        end else begin
          run_res.kind         = KIND_FRAME;
          run_res.repeat_count = 18'd1;
        end
      end
    endcase
  end

  always_comb begin
    hdr_res              = '0;
    hdr_res.kind         = KIND_FRAME;
    hdr_res.repeat_count = rep;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RUN;
      res_valid        <= 1'b0;
      points_remaining <= '0;
      frame_kind       <= FK_NONE;
      rate_offset      <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_entry.cls == CLS_POINT) begin
              res_valid <= 1'b1;
              if (point_ok) begin
                points_remaining <= points_remaining - 1'b1;
                if (points_remaining == 16'd1) frame_kind <= FK_NONE;
              end
            end else if (!hdr_ok || q_entry.point_count == '0) begin
              res_valid        <= 1'b1;
              points_remaining <= '0;
              frame_kind       <= FK_NONE;
            end else if (points_per_frame == '0) begin
              res_valid        <= 1'b1;
              points_remaining <= q_entry.point_count;
              frame_kind       <= new_kind;
            end else begin
              points_remaining <= '0;
              frame_kind       <= FK_NONE;
              state            <= num_small ? ST_MUL : ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (bit_cnt == '0) state <= ST_MUL;
        end
        ST_MUL: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            rate_offset      <= nf_sat;
            points_remaining <= divisor;
            frame_kind       <= hdr_kind;
            state            <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_RUN: begin
        if (q_pop) begin
          res      <= run_res;
          divisor  <= q_entry.point_count;
          hdr_kind <= new_kind;
          rem      <= '0;
          bit_cnt  <= 5'd31;
          // a numerator below n gives a count of one
          dvd      <= num_small ? 32'd1 : num[31:0];
        end
      end
      ST_DIV: begin
        rem     <= ge ? rem_sub[15:0] : rem_sh[15:0];
        dvd     <= {dvd[30:0], ge};
        bit_cnt <= bit_cnt - 1'b1;
      end
      ST_MUL: begin
        rep  <= q_sat;
        prod <= q_sat * divisor;
      end
      ST_FIN: begin
        if (out_free) res <= hdr_res;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ilda_point_frame_decoder.sv =====
// Top level of the laser frame record decoder: config register and block wiring.
//
// Input channel (in_valid/in_ready): one pre-split record per beat, either a
// frame header (command 0) or a point record (command 1). Output channel
// (out_valid/out_ready): exactly one result beat per input beat, in order.
// Config: APB-style write of points_per_frame at address 0; write only
// while the block is idle.
// A point beat passes through the queue and the result register; point
// beats stream at one per cycle while out_ready stays high. A header with
// a non-zero count and a non-zero points_per_frame runs the repeat count
// through a one-bit-per-cycle divider and a multiplier (the divider is
// skipped when the rounded numerator is below the count), during which the
// back end takes nothing from its 4-entry queue while the front end keeps
// filling it. Other headers take the same path as a point.
// Reset (rst, synchronous) empties the queue, closes any open frame, clears
// the rate offset and sets points_per_frame to zero.
// When out_ready is low the result register holds; the queue fills and then
// in_ready drops until the receiver takes the waiting beat.
module ilda_point_frame_decoder #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  format_code,
  input  logic [15:0] point_count,
  input  logic [15:0] x_in,
  input  logic [15:0] y_in,
  input  logic [7:0]  status,
  input  logic [7:0]  color_index,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] x_out,
  output logic [15:0] y_out,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic [15:0] intensity,
  output logic [17:0] repeat_count,
  output logic        frame_last
);
  import idfd_pkg::*;

  logic [16:0] points_per_frame;
  logic        cfg_write;
  logic        reg_sel;

  entry_t  fe_entry;
  entry_t  q_entry;
  logic    q_write;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_frame <= '0;
    end else if (cfg_write && reg_sel == REG_POINTS_PER_FRAME) begin
      points_per_frame <= pwdata[16:0];
    end
  end

  assign prdata = (reg_sel == REG_POINTS_PER_FRAME) ? {15'b0, points_per_frame} : '0;

  idfd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .format_code (format_code),
    .point_count (point_count),
    .x_in        (x_in),
    .y_in        (y_in),
    .status      (status),
    .color_index (color_index),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .q_full      (q_full),
    .q_write     (q_write),
    .q_entry     (fe_entry)
  );

  idfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_write),
    .wr_entry (fe_entry),
    .pop      (q_pop),
    .rd_entry (q_entry),
    .rd_valid (q_valid),
    .full     (q_full)
  );

  idfd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_entry          (q_entry),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .points_per_frame (points_per_frame),
    .res              (res),
    .res_valid        (out_valid),
    .res_ready        (out_ready)
  );

  assign kind         = res.kind;
  assign x_out        = res.x;
  assign y_out        = res.y;
  assign red_out      = res.red;
  assign green_out    = res.green;
  assign blue_out     = res.blue;
  assign intensity    = res.intensity;
  assign repeat_count = res.repeat_count;
  assign frame_last   = res.frame_last;

endmodule
